@@ src/arfp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, character codes and header tables for the modem response frame parser.
package arfp_pkg;

  typedef enum logic [1:0] {
    OP_BYTE        = 2'd0,
    OP_ACK_PAYLOAD = 2'd1,
    OP_ACK_ERROR   = 2'd2,
    OP_NOP         = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_H0         = 4'd0,
    ST_H1         = 4'd1,
    ST_H2         = 4'd2,
    ST_H3         = 4'd3,
    ST_H4         = 4'd4,
    ST_H5         = 4'd5,
    ST_H6         = 4'd6,
    ST_H7         = 4'd7,
    ST_H8         = 4'd8,
    ST_PAYLOAD    = 4'd9,
    ST_UNUSED     = 4'd10,
    ST_ERROR      = 4'd11,
    ST_LINK_T     = 4'd12,
    ST_LINK_E     = 4'd13,
    ST_LINK_COLON = 4'd14,
    ST_LINK_DIGIT = 4'd15
  } parse_state_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_OFFLINE = 2'd1,
    EV_ONLINE  = 2'd2,
    EV_RSVD    = 2'd3
  } link_event_t;

  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_A_UP    = 8'h41;
  localparam logic [7:0] CH_C_UP    = 8'h43;
  localparam logic [7:0] CH_E_UP    = 8'h45;
  localparam logic [7:0] CH_M_UP    = 8'h4D;
  localparam logic [7:0] CH_O_UP    = 8'h4F;
  localparam logic [7:0] CH_Q_UP    = 8'h51;
  localparam logic [7:0] CH_R_UP    = 8'h52;
  localparam logic [7:0] CH_S_UP    = 8'h53;
  localparam logic [7:0] CH_T_UP    = 8'h54;
  localparam logic [7:0] CH_A_LO    = 8'h61;
  localparam logic [7:0] CH_M_LO    = 8'h6D;
  localparam logic [7:0] CH_P_LO    = 8'h70;
  localparam logic [7:0] CH_R_LO    = 8'h72;
  localparam logic [7:0] CH_S_LO    = 8'h73;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  typedef struct packed {
    parse_state_t st;
    logic         payload_done;
    logic         error_done;
    logic         online;
    logic [6:0]   last_length;
    logic [7:0]   login_tally;
  } ctrl_t;

  typedef struct packed {
    logic        write_enable;
    logic [5:0]  write_index;
    logic [7:0]  write_byte;
    logic        frame_ready;
    logic        error_ready;
    logic [6:0]  frame_length;
    logic        link_online;
    link_event_t link_event;
    logic        capture_overflow;
  } result_t;

  // Loose header match: each header position accepts any of three characters.
  function automatic logic hdr_match(input parse_state_t s, input logic [7:0] b);
    logic m;
    begin
      case (s)
        ST_H0:   m = (b == CH_P_LO) || (b == CH_C_UP) || (b == CH_T_UP);
        ST_H1:   m = (b == CH_A_LO) || (b == CH_M_UP) || (b == CH_C_UP);
        ST_H2:   m = (b == CH_R_LO) || (b == CH_E_UP) || (b == CH_M_UP);
        ST_H3:   m = (b == CH_A_LO) || (b == CH_SPACE) || (b == CH_Q_UP);
        ST_H4:   m = (b == CH_M_LO) || (b == CH_E_UP) || (b == CH_T_UP);
        ST_H5:   m = (b == CH_S_LO) || (b == CH_R_UP) || (b == CH_T_UP);
        ST_H6:   m = (b == CH_DQUOTE) || (b == CH_R_UP) || (b == CH_S_UP);
        ST_H7:   m = (b == CH_COLON) || (b == CH_O_UP) || (b == CH_T_UP);
        default: m = 1'b0;
      endcase
      return m;
    end
  endfunction

endpackage

@@ src/arfp_in_if.sv @@
`timescale 1ns / 1ps
// Request channel carrying one parser operation and its received byte.
interface arfp_in_if;
  import arfp_pkg::*;
  logic       valid;
  logic       ready;
  op_t        op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

@@ src/arfp_out_if.sv @@
`timescale 1ns / 1ps
// Result channel carrying the capture write and parser status for one request.
interface arfp_out_if;
  import arfp_pkg::*;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [5:0]  write_index;
  logic [7:0]  write_byte;
  logic        frame_ready;
  logic        error_ready;
  logic [6:0]  frame_length;
  logic        link_online;
  link_event_t link_event;
  logic        capture_overflow;

  modport source (
    output valid, output write_enable, output write_index, output write_byte,
    output frame_ready, output error_ready, output frame_length,
    output link_online, output link_event, output capture_overflow,
    input ready
  );
  modport sink (
    input valid, input write_enable, input write_index, input write_byte,
    input frame_ready, input error_ready, input frame_length,
    input link_online, input link_event, input capture_overflow,
    output ready
  );
endinterface

@@ src/arfp_step.sv @@
`timescale 1ns / 1ps
// Combinational next-state and result logic for one parser request.
module arfp_step
  import arfp_pkg::*;
#(
  parameter int BUFFER_DEPTH    = 64,
  parameter int ERROR_MAX_BYTES = 5,
  parameter int CW              = $clog2(BUFFER_DEPTH + 1)
) (
  input  op_t           op,
  input  logic [7:0]    rx_byte,
  input  ctrl_t         cur,
  input  logic [CW-1:0] cnt,
  output ctrl_t         nxt,
  output logic [CW-1:0] cnt_next,
  output result_t       res
);

  logic [CW-1:0] cnt_inc;
  logic          full;
  logic          err_done_now;

  assign cnt_inc = cnt + CW'(1);
  assign full    = (cnt >= CW'(BUFFER_DEPTH));

  always_comb begin
    nxt          = cur;
    cnt_next     = cnt;
    err_done_now = 1'b0;
    res          = '0;
    res.link_event = EV_NONE;

    case (op)
      OP_ACK_PAYLOAD: begin
        nxt.payload_done = 1'b0;
      end
      OP_ACK_ERROR: begin
        nxt.error_done = 1'b0;
      end
      OP_BYTE: begin
        case (cur.st)
          ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7: begin
            if (hdr_match(cur.st, rx_byte)) begin
              nxt.st = parse_state_t'(4'(cur.st) + 4'd1);
            end else if (cur.st == ST_H6 && rx_byte == CH_COLON) begin
              nxt.st = ST_H8;
            end else begin
              nxt.st   = ST_H0;
              cnt_next = '0;
            end
          end
          ST_H8: begin
            if (rx_byte == CH_LBRACE) begin
              nxt.st = ST_PAYLOAD;
            end else if (rx_byte == CH_R_UP) begin
              nxt.st = ST_ERROR;
            end else if (rx_byte == CH_A_UP) begin
              nxt.st = ST_LINK_T;
            end else begin
              nxt.st   = ST_H0;
              cnt_next = '0;
            end
          end
          ST_PAYLOAD: begin
            if (cur.payload_done) begin
              // The previous frame was never acknowledged, so this one is dropped.
              nxt.payload_done = 1'b0;
              nxt.last_length  = '0;
              nxt.st           = ST_H0;
              cnt_next         = '0;
            end else begin
              if (!full) begin
                res.write_enable = 1'b1;
                res.write_index  = 6'(cnt);
                res.write_byte   = rx_byte;
                cnt_next         = cnt_inc;
              end else begin
                res.capture_overflow = 1'b1;
              end
              if (rx_byte == CH_RBRACE || rx_byte == CH_LF) begin
                nxt.payload_done = 1'b1;
                nxt.last_length  = 7'(cnt_next);
                nxt.st           = ST_H0;
                cnt_next         = '0;
              end
            end
          end
          ST_ERROR: begin
            if (cur.error_done) begin
              nxt.error_done  = 1'b0;
              nxt.last_length = '0;
              nxt.st          = ST_H0;
              cnt_next        = '0;
            end else begin
              if (!full) begin
                res.write_enable = 1'b1;
                res.write_index  = 6'(cnt);
                res.write_byte   = rx_byte;
                cnt_next         = cnt_inc;
              end
              err_done_now = (9'(cnt_next) >= 9'(ERROR_MAX_BYTES)) ||
                             (cnt_next >= CW'(BUFFER_DEPTH)) || (rx_byte == CH_LF);
              if (err_done_now) begin
                nxt.error_done  = 1'b1;
                nxt.last_length = 7'(cnt_next);
                nxt.st          = ST_H0;
                cnt_next        = '0;
              end
            end
          end
          ST_LINK_T: begin
            if (rx_byte == CH_T_UP) begin
              nxt.st = ST_LINK_E;
            end else begin
              nxt.st   = ST_H0;
              cnt_next = '0;
            end
          end
          ST_LINK_E: begin
            if (rx_byte == CH_E_UP) begin
              nxt.st = ST_LINK_COLON;
            end else begin
              nxt.st   = ST_H0;
              cnt_next = '0;
            end
          end
          ST_LINK_COLON: begin
            if (rx_byte == CH_COLON) begin
              nxt.st = ST_LINK_DIGIT;
            end else begin
              nxt.st   = ST_H0;
              cnt_next = '0;
            end
          end
          ST_LINK_DIGIT: begin
            if (rx_byte == CH_ZERO) begin
              nxt.online     = 1'b0;
              res.link_event = EV_OFFLINE;
            end else if (rx_byte == CH_ONE) begin
              nxt.online      = 1'b1;
              nxt.login_tally = cur.login_tally + 8'd1;
              res.link_event  = EV_ONLINE;
            end
            nxt.st   = ST_H0;
            cnt_next = '0;
          end
          default: begin
            nxt.st   = ST_H0;
            cnt_next = '0;
          end
        endcase
      end
      default: begin
      end
    endcase

    res.frame_ready  = nxt.payload_done;
    res.error_ready  = nxt.error_done;
    res.frame_length = nxt.last_length;
    res.link_online  = nxt.online;
  end

endmodule

@@ src/at_response_frame_parser_top.sv @@
`timescale 1ns / 1ps
// Top level of the modem response frame parser with input and result registers.
//
// Usage: each request on rx carries an op (received byte, acknowledge payload
// frame, acknowledge error frame, or no operation) and a byte. Every request
// produces exactly one result on res, in order. The result holds the capture
// buffer write for that byte (enable, index, value), the payload and error
// ready flags, the last frame length, the link status and link event, and
// the overflow flag. The caller writes the captured bytes into its own buffer.
// A request passes through the input register and then through the parser
// logic into the result register. Throughput is one request per cycle while
// res is not stalled, since the parser state register is read and written by
// the same request step.
// When res is stalled the result register holds, the input register fills,
// and rx.ready drops only once both are occupied.
// Synchronous reset clears the parser state, the flags, the link status, the
// login count and both valid bits.
module at_response_frame_parser_top
  import arfp_pkg::*;
#(
  parameter int BUFFER_DEPTH    = 64,
  parameter int ERROR_MAX_BYTES = 5
) (
  input logic       clk,
  input logic       rst,
  arfp_in_if.sink   rx,
  arfp_out_if.source res
);

  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  logic          s1_valid;
  op_t           s1_op;
  logic [7:0]    s1_byte;
  logic          fire;

  ctrl_t         ctrl;
  ctrl_t         ctrl_next;
  logic [CW-1:0] byte_count;
  logic [CW-1:0] byte_count_next;

  result_t       step_res;
  result_t       out_res;
  logic          out_valid;

  assign fire     = s1_valid && (!out_valid || res.ready);
  assign rx.ready = !s1_valid || fire;

  arfp_step #(
    .BUFFER_DEPTH    (BUFFER_DEPTH),
    .ERROR_MAX_BYTES (ERROR_MAX_BYTES),
    .CW              (CW)
  ) u_step (
    .op       (s1_op),
    .rx_byte  (s1_byte),
    .cur      (ctrl),
    .cnt      (byte_count),
    .nxt      (ctrl_next),
    .cnt_next (byte_count_next),
    .res      (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_op   <= rx.op;
      s1_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl       <= '0;
      byte_count <= '0;
    end else if (fire) begin
      ctrl       <= ctrl_next;
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= step_res;
    end
  end

  assign res.valid            = out_valid;
  assign res.write_enable     = out_res.write_enable;
  assign res.write_index      = out_res.write_index;
  assign res.write_byte       = out_res.write_byte;
  assign res.frame_ready      = out_res.frame_ready;
  assign res.error_ready      = out_res.error_ready;
  assign res.frame_length     = out_res.frame_length;
  assign res.link_online      = out_res.link_online;
  assign res.link_event       = out_res.link_event;
  assign res.capture_overflow = out_res.capture_overflow;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CW'(BUFFER_DEPTH))
    else $error("capture count exceeds buffer depth");

  a_write_or_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.write_enable && out_res.capture_overflow))
    else $error("byte both stored and reported as overflow");

  a_ack_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && s1_op == OP_ACK_PAYLOAD) |=> (!ctrl.payload_done && !out_res.frame_ready))
    else $error("payload acknowledge did not clear the ready flag");

  a_online_event: assert property (@(posedge clk) disable iff (rst)
    (fire && step_res.link_event == EV_ONLINE) |=> (ctrl.online && ctrl.st == ST_H0))
    else $error("online event without link status update");

endmodule

@@ tb/sv/tb_at_response_frame_parser_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the modem response frame parser with a directed table and random frames.
module tb_at_response_frame_parser_top;
  import arfp_pkg::*;

  localparam int BUF_DEPTH = 64;
  localparam int ERR_MAX = 5;
  localparam int DIRECTED_ROWS = 28;
  localparam int RANDOM_REQUESTS = 1300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 40;

  localparam result_t IDLE_RESULT = '0;
  localparam result_t LINK_UP_RESULT = '{
    write_enable: 1'b0, write_index: 6'd0, write_byte: 8'h00, frame_ready: 1'b0,
    error_ready: 1'b0, frame_length: 7'd0, link_online: 1'b1, link_event: EV_ONLINE,
    capture_overflow: 1'b0
  };
  localparam result_t ERROR_DONE_RESULT = '{
    write_enable: 1'b1, write_index: 6'd1, write_byte: CH_LF, frame_ready: 1'b0,
    error_ready: 1'b1, frame_length: 7'd2, link_online: 1'b1, link_event: EV_NONE,
    capture_overflow: 1'b0
  };

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       typed;
    result_t    want;
  } row_t;

  logic clk;
  logic rst;

  arfp_in_if rx_if ();
  arfp_out_if res_if ();

  at_response_frame_parser_top #(
    .BUFFER_DEPTH(BUF_DEPTH),
    .ERROR_MAX_BYTES(ERR_MAX)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .rx(rx_if),
    .res(res_if)
  );

  parse_state_t pstate;
  logic [6:0]   byte_cnt;
  logic         frame_flag;
  logic         error_flag;
  logic [6:0]   last_len;
  logic         online;
  logic [7:0]   login_cnt;

  result_t expected_results [$];
  int      errors = 0;
  int      requests_sent = 0;
  int      cycles = 0;
  bit      no_idle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_at_response_frame_parser_top failed");
      $finish;
    end
  end

  function automatic logic [7:0] header_char(input int pos, input int k);
    logic [23:0] chars;
    case (pos)
      0: chars = {CH_P_LO, CH_C_UP, CH_T_UP};
      1: chars = {CH_A_LO, CH_M_UP, CH_C_UP};
      2: chars = {CH_R_LO, CH_E_UP, CH_M_UP};
      3: chars = {CH_A_LO, CH_SPACE, CH_Q_UP};
      4: chars = {CH_M_LO, CH_E_UP, CH_T_UP};
      5: chars = {CH_S_LO, CH_R_UP, CH_T_UP};
      6: chars = {CH_DQUOTE, CH_R_UP, CH_S_UP};
      default: chars = {CH_COLON, CH_O_UP, CH_T_UP};
    endcase
    return chars[8*k +: 8];
  endfunction

  function automatic void return_to_idle();
    pstate = ST_H0;
    byte_cnt = 7'd0;
  endfunction

  function automatic result_t advance_parser(input op_t op, input logic [7:0] data);
    result_t r;
    logic    hit;
    r = '0;
    hit = 1'b0;
    if (op == OP_ACK_PAYLOAD) begin
      frame_flag = 1'b0;
    end else if (op == OP_ACK_ERROR) begin
      error_flag = 1'b0;
    end else if (op == OP_BYTE) begin
      case (pstate)
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7: begin
          for (int k = 0; k < 3; k++) begin
            if (data == header_char(int'(pstate), k)) hit = 1'b1;
          end
          if (hit) pstate = parse_state_t'(pstate + 4'd1);
          else if (pstate == ST_H6 && data == CH_COLON) pstate = ST_H8;
          else return_to_idle();
        end
        ST_H8: begin
          case (data)
            CH_LBRACE: pstate = ST_PAYLOAD;
            CH_R_UP:   pstate = ST_ERROR;
            CH_A_UP:   pstate = ST_LINK_T;
            default:   return_to_idle();
          endcase
        end
        ST_PAYLOAD: begin
          if (frame_flag) begin
            frame_flag = 1'b0;
            last_len = 7'd0;
            return_to_idle();
          end else begin
            if (byte_cnt < BUF_DEPTH) begin
              r.write_enable = 1'b1;
              r.write_index = byte_cnt[5:0];
              r.write_byte = data;
              byte_cnt = byte_cnt + 7'd1;
            end else begin
              r.capture_overflow = 1'b1;
            end
            if (data == CH_RBRACE || data == CH_LF) begin
              frame_flag = 1'b1;
              last_len = byte_cnt;
              return_to_idle();
            end
          end
        end
        ST_ERROR: begin
          if (error_flag) begin
            error_flag = 1'b0;
            last_len = 7'd0;
            return_to_idle();
          end else begin
            if (byte_cnt < BUF_DEPTH) begin
              r.write_enable = 1'b1;
              r.write_index = byte_cnt[5:0];
              r.write_byte = data;
              byte_cnt = byte_cnt + 7'd1;
            end
            if (byte_cnt >= ERR_MAX || byte_cnt >= BUF_DEPTH || data == CH_LF) begin
              error_flag = 1'b1;
              last_len = byte_cnt;
              return_to_idle();
            end
          end
        end
        ST_LINK_T: begin
          if (data == CH_T_UP) pstate = ST_LINK_E;
          else return_to_idle();
        end
        ST_LINK_E: begin
          if (data == CH_E_UP) pstate = ST_LINK_COLON;
          else return_to_idle();
        end
        ST_LINK_COLON: begin
          if (data == CH_COLON) pstate = ST_LINK_DIGIT;
          else return_to_idle();
        end
        ST_LINK_DIGIT: begin
          if (data == CH_ZERO) begin
            online = 1'b0;
            r.link_event = EV_OFFLINE;
          end else if (data == CH_ONE) begin
            online = 1'b1;
            login_cnt = login_cnt + 8'd1;
            r.link_event = EV_ONLINE;
          end
          return_to_idle();
        end
        default: return_to_idle();
      endcase
    end
    r.frame_ready = frame_flag;
    r.error_ready = error_flag;
    r.frame_length = last_len;
    r.link_online = online;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    errors++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic compare_result(input result_t got, input result_t want);
    if (got.write_enable !== want.write_enable)
      flag_mismatch($sformatf("write_enable got %0d want %0d", got.write_enable,
                              want.write_enable));
    if (got.write_index !== want.write_index)
      flag_mismatch($sformatf("write_index got %0d want %0d", got.write_index,
                              want.write_index));
    if (got.write_byte !== want.write_byte)
      flag_mismatch($sformatf("write_byte got %0h want %0h", got.write_byte, want.write_byte));
    if (got.frame_ready !== want.frame_ready)
      flag_mismatch($sformatf("frame_ready got %0d want %0d", got.frame_ready,
                              want.frame_ready));
    if (got.error_ready !== want.error_ready)
      flag_mismatch($sformatf("error_ready got %0d want %0d", got.error_ready,
                              want.error_ready));
    if (got.frame_length !== want.frame_length)
      flag_mismatch($sformatf("frame_length got %0d want %0d", got.frame_length,
                              want.frame_length));
    if (got.link_online !== want.link_online)
      flag_mismatch($sformatf("link_online got %0d want %0d", got.link_online,
                              want.link_online));
    if (got.link_event !== want.link_event)
      flag_mismatch($sformatf("link_event got %0d want %0d", got.link_event, want.link_event));
    if (got.capture_overflow !== want.capture_overflow)
      flag_mismatch($sformatf("capture_overflow got %0d want %0d", got.capture_overflow,
                              want.capture_overflow));
  endtask

  always @(posedge clk) begin : scoreboard
    result_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got = {res_if.write_enable, res_if.write_index, res_if.write_byte, res_if.frame_ready,
             res_if.error_ready, res_if.frame_length, res_if.link_online, res_if.link_event,
             res_if.capture_overflow};
      if (expected_results.size() == 0) flag_mismatch("result with no request outstanding");
      else compare_result(got, expected_results.pop_front());
    end
  end

  initial begin : result_sink
    int pause;
    int taken;
    taken = 0;
    res_if.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (taken == 250 || taken == 800) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pause = no_idle ? 0 : $urandom_range(0, 5);
      if (pause > 0) begin
        res_if.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      taken++;
    end
  end

  task automatic send_request(input op_t op, input logic [7:0] data, input logic typed,
                              input result_t want);
    int      gap;
    result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.op <= op;
    rx_if.rx_byte <= data;
    do @(posedge clk); while (!rx_if.ready);
    predicted = advance_parser(op, data);
    expected_results.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  task automatic send_byte(input logic [7:0] data);
    send_request(OP_BYTE, data, 1'b0, IDLE_RESULT);
  endtask

  function automatic logic [7:0] random_body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_RBRACE || b == CH_LF);
    return b;
  endfunction

  task automatic send_header(input bit broken);
    int bad;
    int pos;
    bit shortcut;
    bad = broken ? $urandom_range(0, 7) : -1;
    shortcut = ($urandom_range(0, 1) == 1);
    pos = 0;
    while (pos < 8) begin
      if (pos == bad) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pos == 6 && shortcut) begin
        send_byte(CH_COLON);
        pos = 7;
      end else begin
        send_byte(header_char(pos, $urandom_range(0, 2)));
      end
      pos++;
    end
  endtask

  initial begin : stimulus
    row_t rows [DIRECTED_ROWS];
    int   kind;
    int   len;
    int   pick;
    rx_if.valid <= 1'b0;
    rx_if.op <= OP_NOP;
    rx_if.rx_byte <= 8'h00;
    rst <= 1'b1;
    pstate = ST_H0;
    byte_cnt = 7'd0;
    frame_flag = 1'b0;
    error_flag = 1'b0;
    last_len = 7'd0;
    online = 1'b0;
    login_cnt = 8'd0;
    rows = '{
      '{OP_NOP, 8'hFF, 1'b1, IDLE_RESULT},
      '{OP_ACK_PAYLOAD, 8'h00, 1'b1, IDLE_RESULT},
      '{OP_ACK_ERROR, 8'hFF, 1'b1, IDLE_RESULT},
      '{OP_BYTE, 8'h00, 1'b1, IDLE_RESULT},
      '{OP_BYTE, 8'hFF, 1'b1, IDLE_RESULT},
      '{OP_BYTE, CH_T_UP, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_C_UP, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_M_UP, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_Q_UP, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_T_UP, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_T_UP, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_COLON, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_A_UP, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_T_UP, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_E_UP, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_COLON, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_ONE, 1'b1, LINK_UP_RESULT},
      '{OP_BYTE, CH_P_LO, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_A_LO, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_R_LO, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_A_LO, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_M_LO, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_S_LO, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_DQUOTE, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_COLON, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_R_UP, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_E_UP, 1'b0, IDLE_RESULT},
      '{OP_BYTE, CH_LF, 1'b1, ERROR_DONE_RESULT}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_request(rows[i].op, rows[i].data, rows[i].typed, rows[i].want);

    while (requests_sent < DIRECTED_ROWS + RANDOM_REQUESTS) begin
      no_idle = ($urandom_range(0, 7) == 0);
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          if ($urandom_range(0, 3) != 0) send_request(OP_ACK_PAYLOAD, 8'h00, 1'b0, IDLE_RESULT);
          send_header($urandom_range(0, 9) == 0);
          send_byte(CH_LBRACE);
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
          for (int i = 0; i < len; i++) send_byte(random_body_byte());
          pick = $urandom_range(0, 9);
          if (pick < 5) send_byte(CH_RBRACE);
          else if (pick < 9) send_byte(CH_LF);
        end
        4, 5: begin
          if ($urandom_range(0, 3) != 0) send_request(OP_ACK_ERROR, 8'hFF, 1'b0, IDLE_RESULT);
          send_header($urandom_range(0, 9) == 0);
          send_byte(CH_R_UP);
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            if (i == len - 1 && $urandom_range(0, 1)) send_byte(CH_LF);
            else send_byte(random_body_byte());
          end
        end
        6, 7: begin
          send_header($urandom_range(0, 9) == 0);
          send_byte(CH_A_UP);
          send_byte(($urandom_range(0, 15) == 0) ? random_body_byte() : CH_T_UP);
          send_byte(($urandom_range(0, 15) == 0) ? random_body_byte() : CH_E_UP);
          send_byte(($urandom_range(0, 15) == 0) ? random_body_byte() : CH_COLON);
          pick = $urandom_range(0, 9);
          if (pick < 4) send_byte(CH_ZERO);
          else if (pick < 8) send_byte(CH_ONE);
          else send_byte(8'($urandom_range(0, 255)));
        end
        8: begin
          if ($urandom_range(0, 1)) send_header(1'b0);
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          send_request(op_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)), 1'b0,
                       IDLE_RESULT);
        end
      endcase
    end

    rx_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_at_response_frame_parser_top passed");
    end else begin
      $display("tb_at_response_frame_parser_top failed");
    end
    $finish;
  end

endmodule
